@@ rtl/slwc_pkg.sv @@
// package for the sorted list with cursor
// holds the operation and error codes, default sizes and the cell command struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slwc_pkg;

    // default sizes for the top level parameters
    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // fixed field widths on the stream ports
    localparam int KEY_W         = 8;
    localparam int IO_PAYLOAD_W  = 32;
    localparam int MODE_W        = 3;
    localparam int ERR_W         = 2;
    localparam int COUNT_OUT_W   = 5;

    // operation selected by the input beat
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_HEAD   = 3'd2,
        MODE_NEXT   = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    // status reported with each result beat
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 2'd0,
        ERR_END  = 2'd1,
        ERR_FULL = 2'd2
    } err_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [KEY_W-1:0] key;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/slwc_cell.sv @@
// one storage cell of the sorted row: key, payload and its local compare
// shifts right on insert, left on remove, talking only to its two neighbors
// depends on slwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module slwc_cell
    import slwc_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int CNT_W        = 5,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire cell_cmd_t               cmd,
    input  wire logic [PAYLOAD_BITS-1:0] new_payload,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic [CNT_W-1:0]        cursor,
    input  wire logic                    prev_lt,
    input  wire logic [KEY_W-1:0]        left_key,
    input  wire logic [PAYLOAD_BITS-1:0] left_payload,
    input  wire logic [KEY_W-1:0]        right_key,
    input  wire logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                         lt,
    output logic                         slot,
    output logic [KEY_W-1:0]             key,
    output logic [PAYLOAD_BITS-1:0]      payload
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    occupied;

    // local compare: stored key below the new one, only for live entries
    always_comb begin
        occupied = (MY_IDX < count);
        lt       = occupied && (key_reg < cmd.key);
        slot     = prev_lt && !lt;
    end

    // pick hold, new entry, left neighbor or right neighbor
    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.insert) begin
            if (slot) begin
                key_next     = cmd.key;
                payload_next = new_payload;
            end else if (!prev_lt) begin
                key_next     = left_key;
                payload_next = left_payload;
            end
        end else if (cmd.remove) begin
            if (MY_IDX >= cursor) begin
                key_next     = right_key;
                payload_next = right_payload;
            end
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_list_with_cursor.sv @@
// top level of the sorted list with cursor: stream ports, count and cursor
// registers, the row of slwc_cell instances and the registered result beat
// depends on slwc_pkg and slwc_cell
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to CAPACITY entries (8-bit key plus payload) in ascending key
// order, equal keys newest first, with a cursor. Each input beat carries
// an operation in s_tuser (insert, remove at cursor, cursor to head, advance,
// read at cursor) and gives exactly one result beat. All cells compare their
// key with the new one in parallel and shift one place toward or away from
// the insertion or removal point, so the block takes one beat per clock
// while the input is ready, and the result appears in the cycle after the
// input beat is taken. The result sits in an output register; the input stays
// ready whenever that register is empty or being drained. Insert on a full
// list, and remove, advance or read with the cursor at the end, report an
// error and leave the list untouched. Entry storage comes up undefined after
// reset; only entries below the count are ever read.
module sorted_list_with_cursor
    import slwc_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // entry_key[7:0], entry_payload[39:8]
    input  wire logic [2:0]  s_tuser,  // mode[2:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // read_key[7:0], read_payload[39:8],
                                       // error_code[41:40], list_empty[42],
                                       // cursor_at_end[43], entry_count[48:44],
                                       // zero[55:49]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             m_tvalid_reg;
    logic [55:0]      m_tdata_reg, m_tdata_next;

    logic                    accept;
    mode_t                   mode;
    logic [KEY_W-1:0]        in_key;
    logic [63:0]             in_wide;
    logic [PAYLOAD_BITS-1:0] in_payload;
    cell_cmd_t               cmd;

    logic [KEY_W-1:0]        cell_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_slot;

    logic                    at_end;
    logic                    full;
    logic [CNT_W-1:0]        ins_pos;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [63:0]             rd_wide;
    logic [31:0]             cnt_wide;
    err_t                    err;
    logic [KEY_W-1:0]        res_key;
    logic [IO_PAYLOAD_W-1:0] res_payload;

    // input beat unpacking
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign mode       = mode_t'(s_tuser[MODE_W-1:0]);
    assign in_key     = s_tdata[KEY_W-1:0];
    assign in_wide    = 64'(s_tdata[KEY_W +: IO_PAYLOAD_W]);
    assign in_payload = in_wide[PAYLOAD_BITS-1:0];

    assign at_end = (cursor_reg >= count_reg);
    assign full   = (count_reg >= CAP_CNT);

    // broadcast command to the row, only for operations that succeed
    always_comb begin
        cmd.key    = in_key;
        cmd.insert = accept && (mode == MODE_INSERT) && !full;
        cmd.remove = accept && (mode == MODE_REMOVE) && !at_end;
    end

    // row of cells, each wired to its two neighbors
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                    prev_lt;
        logic [KEY_W-1:0]        left_key, right_key;
        logic [PAYLOAD_BITS-1:0] left_payload, right_payload;

        if (gi == 0) begin : g_first
            assign prev_lt      = 1'b1;
            assign left_key     = in_key;
            assign left_payload = in_payload;
        end else begin : g_inner
            assign prev_lt      = cell_lt[gi-1];
            assign left_key     = cell_key[gi-1];
            assign left_payload = cell_payload[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_key     = cell_key[gi];
            assign right_payload = cell_payload[gi];
        end else begin : g_right
            assign right_key     = cell_key[gi+1];
            assign right_payload = cell_payload[gi+1];
        end

        slwc_cell #(
            .IDX          (gi),
            .CNT_W        (CNT_W),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .aclk          (aclk),
            .cmd           (cmd),
            .new_payload   (in_payload),
            .count         (count_reg),
            .cursor        (cursor_reg),
            .prev_lt       (prev_lt),
            .left_key      (left_key),
            .left_payload  (left_payload),
            .right_key     (right_key),
            .right_payload (right_payload),
            .lt            (cell_lt[gi]),
            .slot          (cell_slot[gi]),
            .key           (cell_key[gi]),
            .payload       (cell_payload[gi])
        );
    end

    // encode the one-hot insertion slot and select the entry at the cursor
    always_comb begin
        ins_pos    = '0;
        rd_key     = '0;
        rd_payload = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_slot[i]) begin
                ins_pos = ins_pos | CNT_W'(i);
            end
            if (cursor_reg == CNT_W'(i)) begin
                rd_key     = rd_key | cell_key[i];
                rd_payload = rd_payload | cell_payload[i];
            end
        end
    end

    // next count, cursor and error for the beat in hand
    always_comb begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        err         = ERR_NONE;
        res_key     = '0;
        rd_wide     = 64'(rd_payload);
        res_payload = '0;
        case (mode)
            MODE_INSERT: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    cursor_next = ins_pos + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (at_end) begin
                    err = ERR_END;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_HEAD: begin
                cursor_next = '0;
            end
            MODE_NEXT: begin
                if (at_end) begin
                    err = ERR_END;
                end else begin
                    cursor_next = cursor_reg + CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (at_end) begin
                    err = ERR_END;
                end else begin
                    res_key     = rd_key;
                    res_payload = rd_wide[IO_PAYLOAD_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // pack the result beat
    always_comb begin
        cnt_wide     = 32'(count_next);
        m_tdata_next = '0;
        m_tdata_next[KEY_W-1:0]              = res_key;
        m_tdata_next[KEY_W +: IO_PAYLOAD_W]  = res_payload;
        m_tdata_next[41:40]                  = err;
        m_tdata_next[42]                     = (count_next == '0);
        m_tdata_next[43]                     = (cursor_next >= count_next);
        m_tdata_next[48:44]                  = cnt_wide[COUNT_OUT_W-1:0];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                cursor_reg   <= cursor_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result data register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_list_with_cursor.sv @@
// self-checking testbench for sorted_list_with_cursor: directed and random
// list operations with random idling on both channels; depends on slwc_pkg
// and the rtl of sorted_list_with_cursor
`timescale 1ns / 1ps

module tb_sorted_list_with_cursor;
    import slwc_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int BURST_LEN = 20;
    localparam int BURSTS_PER_PHASE = 9;
    // operation codes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]       op;
        logic [KEY_W-1:0]        key;
        logic [IO_PAYLOAD_W-1:0] payload;
    } list_cmd_t;

    typedef struct {
        logic [KEY_W-1:0]        key;
        logic [IO_PAYLOAD_W-1:0] payload;
        err_t                    err;
        logic                    empty;
        logic                    at_end;
        logic [COUNT_OUT_W-1:0]  count;
    } list_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    sorted_list_with_cursor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the list
    logic [KEY_W-1:0]        key_shadow[LIST_DEPTH];
    logic [IO_PAYLOAD_W-1:0] payload_shadow[LIST_DEPTH];
    int                      shadow_count = 0;
    int                      shadow_cursor = 0;

    list_cmd_t    pending_cmds[$];
    list_status_t awaited_status[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         s_taken = 1'b0;

    always #5 aclk = ~aclk;

    // apply one operation to the shadow list and return the status it gives
    function automatic list_status_t apply_list_op(input list_cmd_t c);
        list_status_t r;
        int           slot;
        int           i;
        logic         past_end;
        r.key = '0;
        r.payload = '0;
        r.err = ERR_NONE;
        past_end = (shadow_cursor >= shadow_count);
        case (c.op)
            MODE_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.err = ERR_FULL;
                end else begin
                    slot = 0;
                    while (slot < shadow_count && key_shadow[slot] < c.key) slot++;
                    for (i = shadow_count; i > slot; i--) begin
                        key_shadow[i] = key_shadow[i-1];
                        payload_shadow[i] = payload_shadow[i-1];
                    end
                    key_shadow[slot] = c.key;
                    payload_shadow[slot] = c.payload;
                    shadow_count++;
                    shadow_cursor = slot + 1;
                end
            end
            MODE_REMOVE: begin
                if (past_end) begin
                    r.err = ERR_END;
                end else begin
                    for (i = shadow_cursor; i + 1 < shadow_count; i++) begin
                        key_shadow[i] = key_shadow[i+1];
                        payload_shadow[i] = payload_shadow[i+1];
                    end
                    shadow_count--;
                end
            end
            MODE_HEAD: shadow_cursor = 0;
            MODE_NEXT: begin
                if (past_end) r.err = ERR_END;
                else shadow_cursor++;
            end
            MODE_READ: begin
                if (past_end) begin
                    r.err = ERR_END;
                end else begin
                    r.key = key_shadow[shadow_cursor];
                    r.payload = payload_shadow[shadow_cursor];
                end
            end
            default: ;
        endcase
        r.empty = (shadow_count == 0);
        r.at_end = (shadow_cursor >= shadow_count);
        r.count = shadow_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    task automatic push_cmd(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [IO_PAYLOAD_W-1:0] payload);
        list_cmd_t c;
        c.op = op;
        c.key = key;
        c.payload = payload;
        pending_cmds.push_back(c);
    endtask

    // random burst: insert share and key spread vary so the list both fills
    // up to capacity and drains, with repeated keys now and then
    task automatic push_random_burst(input int insert_pct, input bit narrow_keys);
        int               pick;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  key;
        for (int n = 0; n < BURST_LEN; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct) begin
                op = MODE_INSERT;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) op = MODE_REMOVE;
                else if (pick < 35) op = MODE_HEAD;
                else if (pick < 65) op = MODE_NEXT;
                else if (pick < 95) op = MODE_READ;
                else op = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            end
            if (narrow_keys) key = KEY_W'($urandom_range(0, 7));
            else key = KEY_W'($urandom_range(0, 255));
            push_cmd(op, key, $urandom);
        end
    endtask

    task automatic drain_all;
        while (pending_cmds.size() != 0 || s_tvalid || awaited_status.size() != 0)
            @(posedge aclk);
    endtask

    // input driver, changes at the falling edge
    always @(negedge aclk) begin
        list_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            s_tvalid <= 1'b1;
        end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            c = pending_cmds.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {c.payload, c.key};
            s_tuser <= c.op;
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check and prediction at the rising edge
    always @(posedge aclk) begin
        list_status_t want;
        list_cmd_t    c;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (awaited_status.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, m_tdata);
                end else begin
                    want = awaited_status.pop_front();
                    check_field("read_key", want.key, m_tdata[7:0]);
                    check_field("read_payload", want.payload, m_tdata[39:8]);
                    check_field("error_code", want.err, m_tdata[41:40]);
                    check_field("list_empty", want.empty, m_tdata[42]);
                    check_field("cursor_at_end", want.at_end, m_tdata[43]);
                    check_field("entry_count", want.count, m_tdata[48:44]);
                    check_field("padding", 0, m_tdata[55:49]);
                end
            end
            if (s_tvalid && s_tready) begin
                c.op = s_tuser;
                c.key = s_tdata[7:0];
                c.payload = s_tdata[39:8];
                awaited_status.push_back(apply_list_op(c));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int stall_plan[4][2];
        stall_plan = '{'{0, 0}, '{48, 0}, '{0, 48}, '{34, 34}};

        // errors on the empty list, then cursor to head
        push_cmd(MODE_READ, 8'h00, 32'h0);
        push_cmd(MODE_REMOVE, 8'hff, 32'hffffffff);
        push_cmd(MODE_NEXT, 8'h00, 32'h0);
        push_cmd(MODE_HEAD, 8'h00, 32'h0);
        // equal keys go newest first, key extremes
        push_cmd(MODE_INSERT, 8'h80, 32'h0);
        push_cmd(MODE_INSERT, 8'h80, 32'hffffffff);
        push_cmd(MODE_INSERT, 8'h00, 32'h12345678);
        push_cmd(MODE_INSERT, 8'hff, 32'h87654321);
        // fill to capacity, then one insert too many
        for (int k = 0; k < LIST_DEPTH - 4; k++)
            push_cmd(MODE_INSERT, 8'h40 + 8'(k * 16), $urandom);
        push_cmd(MODE_INSERT, 8'h80, 32'hdeadbeef);
        // walk, remove at the cursor, then the operation codes the block ignores
        push_cmd(MODE_HEAD, 8'h00, 32'h0);
        push_cmd(MODE_READ, 8'h00, 32'h0);
        push_cmd(MODE_NEXT, 8'h00, 32'h0);
        push_cmd(MODE_REMOVE, 8'h00, 32'h0);
        push_cmd(MODE_READ, 8'h00, 32'h0);
        push_cmd(MODE_SPARE_LO, 8'hff, 32'hffffffff);
        push_cmd(MODE_SPARE_HI, 8'h00, 32'h0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = stall_plan[ph][0];
            recv_stall_pct = stall_plan[ph][1];
            for (int b = 0; b < BURSTS_PER_PHASE; b++)
                push_random_burst(15 + 20 * $urandom_range(0, 3), $urandom_range(0, 2) == 0);
            drain_all();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (awaited_status.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, awaited_status.size());
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
